[rtl/core/grlos_pkg.sv]
// ----------------------------------------------------------------------------
// Grid line-of-sight package
// Shared constants, opcodes, CSR indices and the queue depth of the occlusion block.
// ----------------------------------------------------------------------------
package grlos_pkg;

   localparam int MAX_SIDE_DEF   = 32;
   localparam int COORD_BITS_DEF = 21;
   localparam int RADIUS_BITS    = 4;
   localparam int CELL_BITS      = 5;
   localparam int OP_BITS        = 2;

   localparam logic [OP_BITS-1:0] OP_CLEAR = 2'd0;
   localparam logic [OP_BITS-1:0] OP_MARK  = 2'd1;
   localparam logic [OP_BITS-1:0] OP_QUERY = 2'd2;
   localparam logic [OP_BITS-1:0] OP_SKIP  = 2'd3;

   localparam logic [1:0] CSR_RADIUS   = 2'd0;
   localparam logic [1:0] CSR_ORIGIN_X = 2'd1;
   localparam logic [1:0] CSR_ORIGIN_Z = 2'd2;

   localparam int QUEUE_DEPTH = 2;

endpackage

[rtl/core/grlos_front.sv]
// ----------------------------------------------------------------------------
// Grid line-of-sight front end
// Accepts transactions, drops unused opcodes and queues the rest.
// ----------------------------------------------------------------------------
module grlos_front #(
   parameter int COORD_BITS = grlos_pkg::COORD_BITS_DEF,
   parameter int ITEM_BITS  = grlos_pkg::OP_BITS + 2 * grlos_pkg::CELL_BITS + 4 * COORD_BITS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  logic [ITEM_BITS-1:0] in_item,
   output logic                 q_valid,
   input  logic                 q_ready,
   output logic [ITEM_BITS-1:0] q_item
);
   import grlos_pkg::*;

   logic [ITEM_BITS-1:0] mem_ff [QUEUE_DEPTH];
   logic                 wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0]           cnt_ff, cnt_in;
   logic                 push, pop;
   logic [OP_BITS-1:0]   op;

   assign op       = in_item[OP_BITS-1:0];
   assign in_ready = (cnt_ff != 2'd2);
   assign push     = in_valid && in_ready && (op != OP_SKIP);
   assign q_valid  = (cnt_ff != 2'd0);
   assign pop      = q_valid && q_ready;
   assign q_item   = mem_ff[rp_ff];

   always_comb begin
      wp_in  = push ? ~wp_ff : wp_ff;
      rp_in  = pop ? ~rp_ff : rp_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (push) mem_ff[wp_ff] <= in_item;
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= 2'd2) else $error("queue overflow");
   a_empty_no_pop: assert property (@(posedge clock) disable iff (reset)
      cnt_ff == 2'd0 |-> !pop) else $error("pop from empty queue");
   a_count: assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> cnt_ff == $past(cnt_ff) + 2'd1) else $error("count slip");
endmodule

[rtl/core/grlos_back.sv]
// ----------------------------------------------------------------------------
// Grid line-of-sight back end
// Executes clear, mark and query items against the opaque cell map.
// ----------------------------------------------------------------------------
module grlos_back #(
   parameter int COORD_BITS = grlos_pkg::COORD_BITS_DEF,
   parameter int ITEM_BITS  = grlos_pkg::OP_BITS + 2 * grlos_pkg::CELL_BITS + 4 * COORD_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                q_valid,
   output logic                                q_ready,
   input  logic [ITEM_BITS-1:0]                q_item,
   input  logic [grlos_pkg::RADIUS_BITS-1:0]   radius,
   input  logic signed [COORD_BITS-1:0]        org_x,
   input  logic signed [COORD_BITS-1:0]        org_z,
   output logic                                out_valid,
   input  logic                                out_ready,
   output logic                                out_occluded
);
   import grlos_pkg::*;

   localparam int SB = $clog2(MAX_SIDE_DEF);
   localparam int DEPTH = MAX_SIDE_DEF * MAX_SIDE_DEF;
   localparam int AB = 2 * SB;
   localparam int W = COORD_BITS + 3;

   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_CLEAR = 6'b000010,
      S_TGT   = 6'b000100,
      S_STEP  = 6'b001000,
      S_CHECK = 6'b010000,
      S_OUT   = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   logic             mem_ff [DEPTH];
   logic             opq_ff;
   logic [AB-1:0]    clr_ff, clr_in;
   logic             built_ff, built_in;
   logic             res_ff, res_in;
   logic signed [W-1:0] x_ff, x_in, z_ff, z_in, tx_ff, tx_in, tz_ff, tz_in;
   logic signed [W-1:0] ax2_ff, ax2_in, az2_ff, az2_in, err_ff, err_in;
   logic signed [W-1:0] lim_ff, lim_in;
   logic sx_ff, sx_in, sz_ff, sz_in, dx0_ff, dx0_in, dz0_ff, dz0_in;
   logic cell_ff, cell_in;

   logic [OP_BITS-1:0]   op;
   logic [CELL_BITS-1:0] cdx, cdz;
   logic signed [COORD_BITS-1:0] itx, itz, icx, icz;
   logic signed [W-1:0] side, ox, oz, dxw, dzw, ax, az;
   logic                wr;
   logic [AB-1:0]       waddr, rd_addr;
   logic                in_map, pastx, pastz, hit_t;
   logic signed [W-1:0] px, pz, nx, nz;

   assign op  = q_item[OP_BITS-1:0];
   assign cdx = q_item[OP_BITS +: CELL_BITS];
   assign cdz = q_item[OP_BITS+CELL_BITS +: CELL_BITS];
   assign itx = q_item[OP_BITS+2*CELL_BITS +: COORD_BITS];
   assign itz = q_item[OP_BITS+2*CELL_BITS+COORD_BITS +: COORD_BITS];
   assign icx = q_item[OP_BITS+2*CELL_BITS+2*COORD_BITS +: COORD_BITS];
   assign icz = q_item[OP_BITS+2*CELL_BITS+3*COORD_BITS +: COORD_BITS];

   always_comb begin
      side = W'({radius, 1'b1});
      if (side > W'(MAX_SIDE_DEF)) side = W'(MAX_SIDE_DEF);
   end
   assign ox = W'(org_x);
   assign oz = W'(org_z);

   // The map is read at the next probe position, so opq_ff holds the cell
   // at x_ff/z_ff (target first, then walk points) alongside them.
   assign nx = x_in - ox;
   assign nz = z_in - oz;
   assign rd_addr = {nz[SB-1:0], nx[SB-1:0]};

   assign px = x_ff - ox;
   assign pz = z_ff - oz;
   assign in_map = (px >= 0) && (pz >= 0) && (px < side) && (pz < side);
   assign hit_t = (x_ff == tx_ff) && (z_ff == tz_ff);
   assign pastx = (x_ff >= ox + side && (sx_ff || dx0_ff)) || (x_ff < ox && (!sx_ff || dx0_ff));
   assign pastz = (z_ff >= oz + side && (sz_ff || dz0_ff)) || (z_ff < oz && (!sz_ff || dz0_ff));

   assign dxw = W'(itx) - W'(icx);
   assign dzw = W'(itz) - W'(icz);
   assign ax  = dxw < 0 ? -dxw : dxw;
   assign az  = dzw < 0 ? -dzw : dzw;

   assign q_ready      = (state_ff == S_IDLE);
   assign out_valid    = (state_ff == S_OUT);
   assign out_occluded = res_ff;

   always_comb begin
      state_in = state_ff; clr_in = clr_ff; built_in = built_ff; res_in = res_ff;
      x_in = x_ff; z_in = z_ff; tx_in = tx_ff; tz_in = tz_ff;
      ax2_in = ax2_ff; az2_in = az2_ff; err_in = err_ff; lim_in = lim_ff;
      sx_in = sx_ff; sz_in = sz_ff; dx0_in = dx0_ff; dz0_in = dz0_ff;
      cell_in = cell_ff; wr = 1'b0; waddr = '0;
      case (state_ff)
         S_IDLE: if (q_valid) begin
            if (op == OP_CLEAR) begin
               clr_in = '0; built_in = 1'b1; state_in = S_CLEAR;
            end else if (op == OP_MARK) begin
               if (W'(cdx) < side && W'(cdz) < side) begin
                  wr = 1'b1; waddr = {cdz[SB-1:0], cdx[SB-1:0]};
               end
            end else begin
               tx_in = W'(itx); tz_in = W'(itz); x_in = W'(itx); z_in = W'(itz);
               sx_in = dxw > 0; sz_in = dzw > 0; dx0_in = dxw == 0; dz0_in = dzw == 0;
               ax2_in = ax <<< 1; az2_in = az <<< 1; err_in = ax - az;
               lim_in = ax + az;
               res_in = 1'b0;
               if (!built_ff) state_in = S_OUT;
               else state_in = S_TGT;
               // Same cell or a direct neighbor: nothing to walk.
               cell_in = (ax <= 1) && (az <= 1);
            end
         end
         S_CLEAR: begin
            wr = 1'b1; waddr = clr_ff;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == AB'(DEPTH - 1)) state_in = S_IDLE;
         end
         S_TGT: begin
            if (in_map && opq_ff) begin
               res_in = 1'b1; state_in = S_OUT;
            end else if (cell_ff) begin
               state_in = S_OUT;
            end else begin
               // Rebuild camera from target and distances.
               x_in = tx_ff - (sx_ff ? (ax2_ff >>> 1) : -(ax2_ff >>> 1));
               z_in = tz_ff - (sz_ff ? (az2_ff >>> 1) : -(az2_ff >>> 1));
               state_in = S_STEP;
            end
         end
         S_STEP: begin
            if (lim_ff == 0) state_in = S_OUT;
            else begin
               lim_in = lim_ff - 1'b1;
               if (err_ff > 0) begin
                  x_in = sx_ff ? x_ff + 1'b1 : x_ff - 1'b1; err_in = err_ff - az2_ff;
               end else if (err_ff < 0) begin
                  z_in = sz_ff ? z_ff + 1'b1 : z_ff - 1'b1; err_in = err_ff + ax2_ff;
               end else begin
                  x_in = sx_ff ? x_ff + 1'b1 : x_ff - 1'b1;
                  z_in = sz_ff ? z_ff + 1'b1 : z_ff - 1'b1;
                  err_in = err_ff + ax2_ff - az2_ff;
               end
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (hit_t) state_in = S_OUT;
            else if (in_map && opq_ff) begin
               res_in = 1'b1; state_in = S_OUT;
            end else if (pastx || pastz) state_in = S_OUT;
            else state_in = S_STEP;
         end
         S_OUT: if (out_ready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff   <= '0;
         built_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         built_ff <= built_in;
      end
      res_ff <= res_in; x_ff <= x_in; z_ff <= z_in; tx_ff <= tx_in; tz_ff <= tz_in;
      ax2_ff <= ax2_in; az2_ff <= az2_in; err_ff <= err_in; lim_ff <= lim_in;
      sx_ff <= sx_in; sz_ff <= sz_in; dx0_ff <= dx0_in; dz0_ff <= dz0_in;
      cell_ff <= cell_in;
      if (wr) mem_ff[waddr] <= (state_ff == S_IDLE);
      opq_ff <= mem_ff[rd_addr];
   end

   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      out_valid && !out_ready |=> out_valid && $stable(out_occluded))
      else $error("result changed while stalled");
   a_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff != S_IDLE |-> !q_ready) else $error("ready while busy");
   a_unbuilt: assert property (@(posedge clock) disable iff (reset)
      out_valid && !built_ff |-> !out_occluded) else $error("occluded before build");
endmodule

[rtl/core/grid_ray_occlusion_test.sv]
// ----------------------------------------------------------------------------
// Grid ray occlusion test
// Line-of-sight queries over a square opaque-cell map.
// ----------------------------------------------------------------------------
// A clear wipes every cell of the map in turn, and the same clearing pass
// runs after reset; meanwhile at most two transactions are queued and then
// req_tready drops. A mark is written straight from the idle state. A query
// walks the line, alternating a step state and a check state, with one step
// and one registered map read per pair; it often ends early, once the walk
// has left the map. A two-entry queue separates the input from the executing
// back end. The opcode travels on req_tuser.
module grid_ray_occlusion_test #(
   parameter int COORD_BITS = grlos_pkg::COORD_BITS_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // opcode
   input  logic [grlos_pkg::OP_BITS-1:0] req_tuser,
   // cell_dx, cell_dz, target_x, target_z, camera_x, camera_z
   input  logic [((2*grlos_pkg::CELL_BITS + 4*COORD_BITS + 7)/8)*8-1:0]
                req_tdata,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // occluded
   output logic [7:0] rsp_tdata,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [1:0] csr_index,
   input  logic [COORD_BITS-1:0] csr_data
);
   import grlos_pkg::*;

   localparam int ITEM_BITS = OP_BITS + 2 * CELL_BITS + 4 * COORD_BITS;

   logic [RADIUS_BITS-1:0] radius_ff;
   logic [COORD_BITS-1:0]  org_x_ff, org_z_ff;
   logic                   q_valid, q_ready, occ;
   logic [ITEM_BITS-1:0]   q_item;

   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= '0; org_x_ff <= '0; org_z_ff <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_RADIUS:   radius_ff <= csr_data[RADIUS_BITS-1:0];
            CSR_ORIGIN_X: org_x_ff  <= csr_data;
            CSR_ORIGIN_Z: org_z_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   grlos_front #(.COORD_BITS(COORD_BITS)) u_front (
      .clock, .reset, .in_valid(req_tvalid), .in_ready(req_tready),
      .in_item({req_tdata[ITEM_BITS-OP_BITS-1:0], req_tuser}), .q_valid, .q_ready,
      .q_item);

   grlos_back #(.COORD_BITS(COORD_BITS)) u_back (
      .clock, .reset, .q_valid, .q_ready, .q_item, .radius(radius_ff),
      .org_x(org_x_ff), .org_z(org_z_ff), .out_valid(rsp_tvalid),
      .out_ready(rsp_tready), .out_occluded(occ));

   assign rsp_tdata = {7'd0, occ};
endmodule
